/* rtl/core/skf_pkg.sv */
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types, register map and microcode program of the scalar Kalman core.
// ----------------------------------------------------------------------------
package skf_pkg;

  // Fixed-point constants
  localparam int unsigned DataW  = 32;
  localparam int unsigned GainW  = 17;
  localparam int unsigned FracW  = 16;
  localparam logic [DataW-1:0] OneQ16 = 32'h0001_0000;
  localparam logic [GainW-1:0] GainOne = 17'h1_0000;

  // Divider: one quotient bit from the setup step, then one per loop pass
  localparam int unsigned DivSteps = 16;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam logic [CntW-1:0] CntLast = CntW'(DivSteps - 1);

  // Register map (word index)
  localparam int unsigned AddrW = 4;
  localparam logic [1:0] RegProcNoise = 2'd0;
  localparam logic [1:0] RegMeasNoise = 2'd1;
  localparam logic [1:0] RegInitEst   = 2'd2;
  localparam logic [1:0] RegInitCov   = 2'd3;

  // Microcode addresses
  localparam int unsigned UaW = 4;
  localparam logic [UaW-1:0] UaPred    = 4'd0;
  localparam logic [UaW-1:0] UaDen     = 4'd1;
  localparam logic [UaW-1:0] UaDivInit = 4'd2;
  localparam logic [UaW-1:0] UaDivStep = 4'd3;
  localparam logic [UaW-1:0] UaMulEst  = 4'd4;
  localparam logic [UaW-1:0] UaUpdEst  = 4'd5;
  localparam logic [UaW-1:0] UaMulCov  = 4'd6;
  localparam logic [UaW-1:0] UaUpdCov  = 4'd7;
  localparam logic [UaW-1:0] UaReload  = 4'd8;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_PRED,
    OP_DEN,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_EST,
    OP_UPD_EST,
    OP_MUL_COV,
    OP_UPD_COV,
    OP_RELOAD
  } op_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_CMD,
    JMP_LOOP
  } jmp_e;

  typedef struct packed {
    op_e            op;
    jmp_e           jmp;
    logic [UaW-1:0] target;
    logic           last;
  } ucode_t;

  localparam ucode_t UcodeNop = '{op: OP_NOP, jmp: JMP_NONE, target: UaPred, last: 1'b0};

  // Microcode ROM
  function automatic ucode_t skf_ucode(logic [UaW-1:0] addr);
    ucode_t w;
    w = UcodeNop;
    unique case (addr)
      UaPred:    w = '{op: OP_PRED,     jmp: JMP_CMD,  target: UaReload,  last: 1'b0};
      UaDen:     w = '{op: OP_DEN,      jmp: JMP_NONE, target: UaPred,    last: 1'b0};
      UaDivInit: w = '{op: OP_DIV_INIT, jmp: JMP_NONE, target: UaPred,    last: 1'b0};
      UaDivStep: w = '{op: OP_DIV_STEP, jmp: JMP_LOOP, target: UaDivStep, last: 1'b0};
      UaMulEst:  w = '{op: OP_MUL_EST,  jmp: JMP_NONE, target: UaPred,    last: 1'b0};
      UaUpdEst:  w = '{op: OP_UPD_EST,  jmp: JMP_NONE, target: UaPred,    last: 1'b0};
      UaMulCov:  w = '{op: OP_MUL_COV,  jmp: JMP_NONE, target: UaPred,    last: 1'b0};
      UaUpdCov:  w = '{op: OP_UPD_COV,  jmp: JMP_NONE, target: UaPred,    last: 1'b1};
      UaReload:  w = '{op: OP_RELOAD,   jmp: JMP_NONE, target: UaPred,    last: 1'b1};
      default:   w = '{op: OP_NOP,      jmp: JMP_NONE, target: UaPred,    last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/skf_seq.sv */
// ----------------------------------------------------------------------------
// skf_seq
// Microcode sequencer: step counter, loop counter and conditional jumps.
// ----------------------------------------------------------------------------
module skf_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            cmd_i,
  input  logic            hold_i,
  output logic            busy_o,
  output skf_pkg::ucode_t uop_o
);

  logic                         busy_q, busy_d;
  logic [skf_pkg::UaW-1:0]      pc_q, pc_d;
  logic [skf_pkg::CntW-1:0]     cnt_q, cnt_d;
  skf_pkg::ucode_t              rom;
  logic                         stall;
  logic [skf_pkg::UaW-1:0]      pc_inc;

  assign rom    = skf_pkg::skf_ucode(pc_q);
  assign stall  = rom.last & hold_i;
  assign pc_inc = pc_q + skf_pkg::UaW'(1);
  assign busy_o = busy_q;
  assign uop_o  = (busy_q && !stall) ? rom : skf_pkg::UcodeNop;

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    cnt_d  = cnt_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = skf_pkg::UaPred;
        cnt_d  = '0;
      end
    end else if (!stall) begin
      if (rom.last) begin
        busy_d = 1'b0;
      end else begin
        case (rom.jmp)
          skf_pkg::JMP_CMD: begin
            pc_d = cmd_i ? rom.target : pc_inc;
          end
          skf_pkg::JMP_LOOP: begin
            if (cnt_q != skf_pkg::CntLast) begin
              pc_d  = rom.target;
              cnt_d = cnt_q + skf_pkg::CntW'(1);
            end else begin
              pc_d  = pc_inc;
              cnt_d = '0;
            end
          end
          default: begin
            pc_d = pc_inc;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= skf_pkg::UaPred;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* rtl/core/scalar_kalman_filter_core.sv */
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core
// One-dimensional constant-value Kalman filter in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Each input transaction carries a sample in tdata and a command in tuser:
// 0 filters the sample as a measurement, 1 reloads the estimate with it
// (covariance back to 1.0, gain to 0). Every transaction yields exactly one
// output transaction holding the estimate, gain and covariance after it. An
// update runs the microcode program after the accept: one
// step each for the covariance prediction and the divider denominator, 17
// steps of the restoring divider that forms the gain one quotient bit
// at a time, and two multiply/update pairs on the single 18x34 multiplier.
// A reload command takes 2 program steps. The divider loop is longest.
// A finished result sits in the output register, so the next sample is taken
// while it waits; the program only stalls on its last step if the previous
// result has still not been taken. Write the APB registers only while idle;
// writing the initial estimate or covariance also loads the live state.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [skf_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample
  input  logic        s_axis_tuser,   // [0] cmd
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata    // [31:0] estimate, [48:32] gain,
                                      // [80:49] covariance, [87:81] zero
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] proc_noise_q, meas_noise_q, init_est_q, init_cov_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_noise_q <= 32'd655;
      meas_noise_q <= 32'd6554;
      init_est_q   <= '0;
      init_cov_q   <= skf_pkg::OneQ16;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        skf_pkg::RegProcNoise: proc_noise_q <= pwdata;
        skf_pkg::RegMeasNoise: meas_noise_q <= pwdata;
        skf_pkg::RegInitEst:   init_est_q   <= pwdata;
        skf_pkg::RegInitCov:   init_cov_q   <= pwdata;
        default:               ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      skf_pkg::RegProcNoise: prdata = proc_noise_q;
      skf_pkg::RegMeasNoise: prdata = meas_noise_q;
      skf_pkg::RegInitEst:   prdata = init_est_q;
      skf_pkg::RegInitCov:   prdata = init_cov_q;
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input capture and sequencer
  // --------------------------------------------------------------------------
  logic            in_acc;
  logic            busy;
  logic            hold;
  logic            cmd_q;
  logic [31:0]     smp_q;
  skf_pkg::ucode_t uop;

  assign s_axis_tready = ~busy;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  // Stall the final step while the previous result still waits
  assign hold          = m_axis_tvalid & ~m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= s_axis_tuser;
      smp_q <= s_axis_tdata;
    end
  end

  skf_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .cmd_i   (cmd_q),
    .hold_i  (hold),
    .busy_o  (busy),
    .uop_o   (uop)
  );

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic [31:0]               est_q, cov_q;
  logic [31:0]               ppred_q;
  logic [32:0]               den_q;
  logic [33:0]               rem_q;
  logic [skf_pkg::GainW-1:0] quo_q;
  logic signed [51:0]        prod_q;

  logic [32:0]               pq_sum;
  logic [31:0]               ppred_sat;
  logic [32:0]               den_sum;
  logic [33:0]               div_init_r;
  logic                      div_init_ge;
  logic [33:0]               div_sh;
  logic                      div_ge;
  logic [32:0]               innov;
  logic signed [17:0]        mul_a;
  logic signed [33:0]        mul_b;
  logic [skf_pkg::GainW-1:0] one_minus_k;

  // Predicted covariance, saturating at full scale
  assign pq_sum    = {1'b0, cov_q} + {1'b0, proc_noise_q};
  assign ppred_sat = pq_sum[32] ? '1 : pq_sum[31:0];
  assign den_sum   = {1'b0, ppred_q} + {1'b0, meas_noise_q};

  // Ppred <= D, so the integer part of the quotient is a single bit
  assign div_init_r  = {2'b00, ppred_q};
  assign div_init_ge = div_init_r >= {1'b0, den_q};
  assign div_sh      = {rem_q[32:0], 1'b0};
  assign div_ge      = div_sh >= {1'b0, den_q};

  assign innov       = {smp_q[31], smp_q} - {est_q[31], est_q};
  assign one_minus_k = skf_pkg::GainOne - quo_q;

  always_comb begin
    if (uop.op == skf_pkg::OP_MUL_COV) begin
      mul_a = $signed({1'b0, one_minus_k});
      mul_b = $signed({2'b00, ppred_q});
    end else begin
      mul_a = $signed({1'b0, quo_q});
      mul_b = $signed({innov[32], innov});
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (uop.op) inside
      skf_pkg::OP_PRED: begin
        ppred_q <= ppred_sat;
      end
      skf_pkg::OP_DEN: begin
        // Raise a zero denominator to one LSB
        den_q <= (den_sum == '0) ? 33'd1 : den_sum;
      end
      skf_pkg::OP_DIV_INIT: begin
        rem_q <= div_init_ge ? (div_init_r - {1'b0, den_q}) : div_init_r;
        quo_q <= {{(skf_pkg::GainW-1){1'b0}}, div_init_ge};
      end
      skf_pkg::OP_DIV_STEP: begin
        rem_q <= div_ge ? (div_sh - {1'b0, den_q}) : div_sh;
        quo_q <= {quo_q[skf_pkg::GainW-2:0], div_ge};
      end
      skf_pkg::OP_MUL_EST, skf_pkg::OP_MUL_COV: begin
        prod_q <= 52'(mul_a * mul_b);
      end
      default: ;
    endcase
  end

  // Architectural state: estimate and covariance; the gain lives in the
  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q  <= '0;
      cov_q  <= skf_pkg::OneQ16;
    end else if (cfg_wr && cfg_idx == skf_pkg::RegInitEst) begin
      est_q <= pwdata;
    end else if (cfg_wr && cfg_idx == skf_pkg::RegInitCov) begin
      cov_q <= pwdata;
    end else begin
      case (uop.op)
        skf_pkg::OP_UPD_EST: begin
          // floor(K*e / 2^16) added modulo 2^32; the sum stays in range
          est_q <= est_q + prod_q[skf_pkg::FracW +: 32];
        end
        skf_pkg::OP_UPD_COV: begin
          cov_q  <= prod_q[skf_pkg::FracW +: 32];
        end
        skf_pkg::OP_RELOAD: begin
          est_q  <= smp_q;
          cov_q  <= skf_pkg::OneQ16;
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic        out_vld_q;
  logic [80:0] out_q;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (uop.last) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uop.op == skf_pkg::OP_UPD_COV) begin
      out_q <= {prod_q[skf_pkg::FracW +: 32], quo_q, est_q};
    end else if (uop.op == skf_pkg::OP_RELOAD) begin
      out_q <= {skf_pkg::OneQ16, {skf_pkg::GainW{1'b0}}, smp_q};
    end
  end

endmodule
